>>> hw/rtl/sai_pkg.sv
// Shared constants, codes and control structs for the sorted table block.
package sai_pkg;

	// Table geometry
	localparam int CAPACITY = 64;
	localparam int DATA_W   = 32;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int POS_W    = 6;
	localparam int OUTC_W   = 7;
	localparam int STAT_W   = 2;

	typedef logic [1:0] opcode_t;

	// Operation codes
	localparam opcode_t OP_INSERT   = 2'd0;
	localparam opcode_t OP_DELETE   = 2'd1;
	localparam opcode_t OP_LOOKUP   = 2'd2;
	localparam opcode_t OP_FIRST_GT = 2'd3;

	// Result status codes
	localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
	localparam logic [STAT_W-1:0] STAT_MISS = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

	// Per-cell control from the chain to one cell
	typedef struct packed {
		logic cmp;      // register compare flags against the broadcast value
		logic load;     // take the broadcast value
		logic from_lo;  // take the lower neighbor's entry (shift up)
		logic from_hi;  // take the upper neighbor's entry (shift down)
	} cell_ctl_t;

	// Command from the top level to the cell chain
	typedef struct packed {
		logic             cmp;
		logic             ins;
		logic             del;
		logic [IDX_W-1:0] pos;
	} chain_cmd_t;

endpackage

>>> hw/rtl/sai_if.sv
// Valid/ready channel interfaces for the command and response beats.
interface sai_in_if;
	import sai_pkg::*;

	logic              valid;
	logic              ready;
	opcode_t           opcode;
	logic [DATA_W-1:0] operand_value;

	modport source(output valid, output opcode, output operand_value, input ready);
	modport sink(input valid, input opcode, input operand_value, output ready);
endinterface

interface sai_out_if;
	import sai_pkg::*;

	logic              valid;
	logic              ready;
	logic [STAT_W-1:0] status;
	logic [POS_W-1:0]  position;
	logic [OUTC_W-1:0] entry_count;

	modport source(output valid, output status, output position, output entry_count,
		input ready);
	modport sink(input valid, input status, input position, input entry_count,
		output ready);
endinterface

>>> hw/rtl/sorted_array_insert_delete_search.sv
// Sorted table of up to 64 unsigned 32-bit values held in a row of compare-and-shift
// cells. Each command beat (insert, delete, exact lookup, first-greater lookup) gives
// one response beat with status, position and the updated entry count. A command steps
// through encode, search and apply; insert and first-greater lookup take their result
// from the encoded boundaries, while delete and exact lookup run the midpoint binary
// search, which probes one index per cycle (at most 7 probes plus one to detect a
// miss). The cells compare and shift all entries in parallel. The response sits in an
// output register, so a waiting response does not hold off the next command until the
// block has another response ready. No clearing pass is needed after reset.
module sorted_array_insert_delete_search (
	input logic      clk,
	input logic      arst_n,
	sai_in_if.sink   cmd,
	sai_out_if.source rsp
);
	import sai_pkg::*;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_ENC   = 2'd1;
	localparam logic [1:0] S_SRCH  = 2'd2;
	localparam logic [1:0] S_APPLY = 2'd3;

	logic [1:0]        state_q;
	opcode_t           op_q;
	logic [DATA_W-1:0] val_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  ge_q;
	logic [CNT_W-1:0]  gt_q;
	logic [CNT_W-1:0]  lo_q;
	logic [CNT_W-1:0]  hx_q;
	logic [IDX_W-1:0]  pos_q;
	logic [STAT_W-1:0] stat_q;

	logic              rsp_valid_q;
	logic [STAT_W-1:0] rsp_status_q;
	logic [POS_W-1:0]  rsp_pos_q;
	logic [OUTC_W-1:0] rsp_cnt_q;

	logic              accept;
	logic              slot_free;
	logic              apply;
	chain_cmd_t        chain_cmd;
	logic [DATA_W-1:0] chain_data;
	logic [CNT_W-1:0]  first_ge;
	logic [CNT_W-1:0]  first_gt;
	logic [CNT_W:0]    mid_sum;
	logic [CNT_W-1:0]  mid;
	logic [CNT_W-1:0]  cnt_next;

	assign cmd.ready = (state_q == S_IDLE);
	assign accept    = cmd.valid && cmd.ready;
	assign slot_free = !rsp_valid_q || rsp.ready;
	assign apply     = (state_q == S_APPLY) && slot_free;

	// Drive the cell row: compare on acceptance, shift when the result retires
	assign chain_data    = (state_q == S_IDLE) ? cmd.operand_value : val_q;
	assign chain_cmd.cmp = accept;
	assign chain_cmd.ins = apply && (op_q == OP_INSERT) && (stat_q == STAT_OK);
	assign chain_cmd.del = apply && (op_q == OP_DELETE) && (stat_q == STAT_OK);
	assign chain_cmd.pos = pos_q;

	sai_chain u_chain (
		.clk      (clk),
		.ctrl     (chain_cmd),
		.count    (cnt_q),
		.data     (chain_data),
		.first_ge (first_ge),
		.first_gt (first_gt)
	);

	// Binary search probe: mid = floor((lo + hi) / 2) with hi = hx - 1
	assign mid_sum = {1'b0, lo_q} + {1'b0, hx_q} - (CNT_W+1)'(1);
	assign mid     = mid_sum[CNT_W:1];

	// Count after the pending operation retires
	always_comb begin
		cnt_next = cnt_q;
		if (stat_q == STAT_OK) begin
			case (op_q)
				OP_INSERT: cnt_next = cnt_q + CNT_W'(1);
				OP_DELETE: cnt_next = cnt_q - CNT_W'(1);
				default:   cnt_next = cnt_q;
			endcase
		end
	end

	// Sequence one command: encode, search, apply and respond
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_ENC;
					end
				end
				S_ENC: begin
					state_q <= S_SRCH;
				end
				S_SRCH: begin
					if ((op_q == OP_INSERT) || (op_q == OP_FIRST_GT) || (lo_q >= hx_q) ||
						((mid >= ge_q) && (mid < gt_q))) begin
						state_q <= S_APPLY;
					end
				end
				S_APPLY: begin
					if (slot_free) begin
						cnt_q   <= cnt_next;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers of the sequencer
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= cmd.opcode;
			val_q <= cmd.operand_value;
		end
		if (state_q == S_ENC) begin
			ge_q <= first_ge;
			gt_q <= first_gt;
			lo_q <= '0;
			hx_q <= cnt_q;
		end
		if (state_q == S_SRCH) begin
			case (op_q)
				OP_INSERT: begin
					if (cnt_q == CNT_W'(CAPACITY)) begin
						stat_q <= STAT_FULL;
						pos_q  <= '0;
					end else begin
						stat_q <= STAT_OK;
						pos_q  <= gt_q[IDX_W-1:0];
					end
				end
				OP_FIRST_GT: begin
					if (gt_q >= cnt_q) begin
						stat_q <= STAT_MISS;
						pos_q  <= '0;
					end else begin
						stat_q <= STAT_OK;
						pos_q  <= gt_q[IDX_W-1:0];
					end
				end
				default: begin
					if (lo_q >= hx_q) begin
						stat_q <= STAT_MISS;
						pos_q  <= '0;
					end else if (mid < ge_q) begin
						lo_q <= mid + CNT_W'(1);
					end else if (mid >= gt_q) begin
						hx_q <= mid;
					end else begin
						stat_q <= STAT_OK;
						pos_q  <= mid[IDX_W-1:0];
					end
				end
			endcase
		end
	end

	// Response register: load on retire, drop on handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (apply) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (apply) begin
			rsp_status_q <= stat_q;
			rsp_pos_q    <= POS_W'(pos_q);
			rsp_cnt_q    <= OUTC_W'(cnt_next);
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.position    = rsp_pos_q;
	assign rsp.entry_count = rsp_cnt_q;

	// Count never exceeds the table size
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	// An accepted command always moves on to encoding
	a_accept_enc: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_ENC)
		else $error("accepted command did not start encoding");

	// Insert and delete never shift the row in the same cycle
	a_shift_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({chain_cmd.ins, chain_cmd.del}))
		else $error("insert and delete shift together");

	// A rejected insert reports a full table
	a_full_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && (rsp_status_q == STAT_FULL) |-> rsp_cnt_q == OUTC_W'(CAPACITY))
		else $error("full status with table not full");

	// A failed operation reports position zero
	a_miss_pos: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && (rsp_status_q != STAT_OK) |-> rsp_pos_q == '0)
		else $error("nonzero position on failed operation");

	// Deletes and lookups never search past the stored entries
	a_search_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SRCH) |-> (hx_q <= cnt_q))
		else $error("search range beyond stored entries");

endmodule

>>> hw/rtl/sai_cell.sv
// One table cell: holds one entry, compares it and shifts with its neighbors.
module sai_cell (
	input  logic                       clk,
	input  sai_pkg::cell_ctl_t         ctl,
	input  logic                       occ,
	input  logic [sai_pkg::DATA_W-1:0] data,
	input  logic [sai_pkg::DATA_W-1:0] lo_entry,
	input  logic [sai_pkg::DATA_W-1:0] hi_entry,
	output logic [sai_pkg::DATA_W-1:0] entry,
	output logic                       lt,
	output logic                       le
);
	import sai_pkg::*;

	logic [DATA_W-1:0] entry_q;
	logic              lt_q;
	logic              le_q;

	// Update the stored entry: load, shift up, shift down or hold
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			entry_q <= data;
		end else if (ctl.from_lo) begin
			entry_q <= lo_entry;
		end else if (ctl.from_hi) begin
			entry_q <= hi_entry;
		end
	end

	// Capture compare flags; unoccupied cells count as greater
	always_ff @(posedge clk) begin
		if (ctl.cmp) begin
			lt_q <= occ && (entry_q < data);
			le_q <= occ && (entry_q <= data);
		end
	end

	assign entry = entry_q;
	assign lt    = lt_q;
	assign le    = le_q;

endmodule

>>> hw/rtl/sai_chain.sv
// Row of table cells with shift control and boundary encoding.
module sai_chain (
	input  logic                       clk,
	input  sai_pkg::chain_cmd_t        ctrl,
	input  logic [sai_pkg::CNT_W-1:0]  count,
	input  logic [sai_pkg::DATA_W-1:0] data,
	output logic [sai_pkg::CNT_W-1:0]  first_ge,
	output logic [sai_pkg::CNT_W-1:0]  first_gt
);
	import sai_pkg::*;

	logic [DATA_W-1:0]   entry [CAPACITY];
	logic [CAPACITY-1:0] lt;
	logic [CAPACITY-1:0] le;
	logic [CAPACITY-1:0] lt_prev;
	logic [CAPACITY-1:0] le_prev;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		cell_ctl_t         ctl;
		logic              occ;
		logic [DATA_W-1:0] lo_entry;
		logic [DATA_W-1:0] hi_entry;

		// Decode this cell's move from the operation and its place in the row
		assign occ         = CNT_W'(i) < count;
		assign ctl.cmp     = ctrl.cmp;
		assign ctl.load    = ctrl.ins && (IDX_W'(i) == ctrl.pos);
		assign ctl.from_lo = ctrl.ins && (IDX_W'(i) > ctrl.pos);
		assign ctl.from_hi = ctrl.del && (IDX_W'(i) >= ctrl.pos);

		if (i == 0) begin : g_first
			assign lo_entry   = '0;
			assign lt_prev[i] = 1'b1;
			assign le_prev[i] = 1'b1;
		end else begin : g_inner
			assign lo_entry   = entry[i-1];
			assign lt_prev[i] = lt[i-1];
			assign le_prev[i] = le[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign hi_entry = '0;
		end else begin : g_upper
			assign hi_entry = entry[i+1];
		end

		sai_cell u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.occ      (occ),
			.data     (data),
			.lo_entry (lo_entry),
			.hi_entry (hi_entry),
			.entry    (entry[i]),
			.lt       (lt[i]),
			.le       (le[i])
		);
	end

	// Encode the edges of the thermometer flags into indexes
	always_comb begin
		first_ge = lt[CAPACITY-1] ? CNT_W'(CAPACITY) : '0;
		first_gt = le[CAPACITY-1] ? CNT_W'(CAPACITY) : '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (!lt[i] && lt_prev[i]) begin
				first_ge = first_ge | CNT_W'(i);
			end
			if (!le[i] && le_prev[i]) begin
				first_gt = first_gt | CNT_W'(i);
			end
		end
	end

endmodule

>>> dv/sorted_array_insert_delete_search_test.sv
// Self-checking testbench for the sorted table block: directed corner beats, then random traffic.
module sorted_array_insert_delete_search_test;
	import sai_pkg::*;

	localparam int RANDOM_BEATS = 1650;
	localparam int STALL_LIMIT  = 4000;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [POS_W-1:0]  position;
		logic [OUTC_W-1:0] entry_count;
	} table_result_t;

	typedef enum {FILL_MIX, DRAIN_MIX, EVEN_MIX} mix_kind_t;

	// Shadow of the sorted table plus the queue of responses it predicts
	class table_scoreboard;
		logic [DATA_W-1:0] entries[$];
		table_result_t     expected[$];
		int                errors;

		function new();
			errors = 0;
		endfunction

		// Midpoint binary search; -1 when the value is absent
		function int find_exact(logic [DATA_W-1:0] v);
			int lo;
			int hi;
			int mid;
			lo = 0;
			hi = entries.size() - 1;
			while (lo <= hi) begin
				mid = (lo + hi) / 2;
				if (entries[mid] == v)
					return mid;
				if (entries[mid] < v)
					lo = mid + 1;
				else
					hi = mid - 1;
			end
			return -1;
		endfunction

		// Index of the first entry above v; size of the table when none
		function int first_greater(logic [DATA_W-1:0] v);
			int lo;
			int hi;
			int mid;
			int found;
			lo = 0;
			hi = entries.size() - 1;
			found = entries.size();
			while (lo <= hi) begin
				mid = (lo + hi) / 2;
				if (entries[mid] <= v) begin
					lo = mid + 1;
				end else begin
					found = mid;
					hi = mid - 1;
				end
			end
			return found;
		endfunction

		function logic [DATA_W-1:0] pick_stored();
			if (entries.size() == 0)
				return $urandom;
			return entries[$urandom_range(0, entries.size() - 1)];
		endfunction

		function int pending();
			return expected.size();
		endfunction

		// Apply an accepted command beat to the shadow and queue its response
		function void note_command(opcode_t op, logic [DATA_W-1:0] v);
			table_result_t r;
			int            idx;
			r.status = STAT_OK;
			r.position = '0;
			case (op)
				OP_INSERT: begin
					if (entries.size() >= CAPACITY) begin
						r.status = STAT_FULL;
					end else begin
						idx = first_greater(v);
						entries.insert(idx, v);
						r.position = idx[POS_W-1:0];
					end
				end
				OP_DELETE: begin
					idx = find_exact(v);
					if (idx < 0) begin
						r.status = STAT_MISS;
					end else begin
						entries.delete(idx);
						r.position = idx[POS_W-1:0];
					end
				end
				OP_LOOKUP: begin
					idx = find_exact(v);
					if (idx < 0)
						r.status = STAT_MISS;
					else
						r.position = idx[POS_W-1:0];
				end
				default: begin
					idx = first_greater(v);
					if (idx >= entries.size())
						r.status = STAT_MISS;
					else
						r.position = idx[POS_W-1:0];
				end
			endcase
			r.entry_count = OUTC_W'(entries.size());
			expected.push_back(r);
		endfunction

		// Compare a response beat against the oldest prediction
		function void check_response(table_result_t got);
			table_result_t want;
			if (expected.size() == 0) begin
				$display("%0t: unexpected response status %0d position %0d count %0d",
					$time, got.status, got.position, got.entry_count);
				errors++;
				return;
			end
			want = expected.pop_front();
			if (got.status !== want.status) begin
				$display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
				errors++;
			end
			if (got.position !== want.position) begin
				$display("%0t: position expected %0d actual %0d",
					$time, want.position, got.position);
				errors++;
			end
			if (got.entry_count !== want.entry_count) begin
				$display("%0t: entry_count expected %0d actual %0d",
					$time, want.entry_count, got.entry_count);
				errors++;
			end
		endfunction
	endclass

	logic            clk;
	logic            arst_n;
	sai_in_if        cmd_ch();
	sai_out_if       rsp_ch();
	table_scoreboard sb;
	bit              steady;
	int              stall_cycles;

	sorted_array_insert_delete_search i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd_ch),
		.rsp   (rsp_ch)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Idle length: mostly none or short, now and then long
	function automatic int gap_len();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [DATA_W-1:0] rand_value();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return $urandom_range(0, 31);
		if (r < 6) begin
			case ($urandom_range(0, 3))
				0: return 32'h0000_0000;
				1: return 32'hFFFF_FFFF;
				2: return 32'h8000_0000;
				default: return 32'h7FFF_FFFF;
			endcase
		end
		return $urandom;
	endfunction

	// Drive one command beat, hold it until accepted
	task automatic send_command(opcode_t op, logic [DATA_W-1:0] v);
		int gap;
		gap = gap_len();
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.opcode <= op;
		cmd_ch.operand_value <= v;
		do
			@(posedge clk);
		while (!cmd_ch.ready);
		@(negedge clk);
	endtask

	// Hold off the sender until every response is back
	task automatic drain_responses();
		cmd_ch.valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	// Random beat shaped by the current mix
	task automatic send_random(mix_kind_t mix);
		int      r;
		opcode_t op;
		r = $urandom_range(0, 99);
		case (mix)
			FILL_MIX:  op = (r < 80) ? OP_INSERT : (r < 88) ? OP_LOOKUP :
				(r < 94) ? OP_FIRST_GT : OP_DELETE;
			DRAIN_MIX: op = (r < 65) ? OP_DELETE : (r < 75) ? OP_INSERT :
				(r < 88) ? OP_LOOKUP : OP_FIRST_GT;
			default:   op = (r < 25) ? OP_INSERT : (r < 50) ? OP_DELETE :
				(r < 75) ? OP_LOOKUP : OP_FIRST_GT;
		endcase
		case (op)
			OP_INSERT:   send_command(op, rand_value());
			OP_FIRST_GT: send_command(op, ($urandom_range(0, 1) == 1) ? sb.pick_stored() :
				rand_value());
			default:     send_command(op, ($urandom_range(0, 3) != 0) ? sb.pick_stored() :
				rand_value());
		endcase
	endtask

	// Note accepted commands, check accepted responses
	always @(posedge clk) begin
		if (arst_n && cmd_ch.valid && cmd_ch.ready)
			sb.note_command(cmd_ch.opcode, cmd_ch.operand_value);
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			sb.check_response({rsp_ch.status, rsp_ch.position, rsp_ch.entry_count});
	end

	// Watchdog: end the run when no beat moves for too long
	always @(posedge clk) begin
		if (!arst_n || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("sorted_array_insert_delete_search regression: fail");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// Response side: toggle ready with random stalls
	initial begin
		int n;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			rsp_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(negedge clk);
			n = gap_len();
			if (n > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (n) @(negedge clk);
			end
		end
	end

	initial begin
		int        sent;
		int        phase;
		int        len;
		mix_kind_t mix;
		sb = new();
		steady = 1'b0;
		arst_n = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.opcode = OP_INSERT;
		cmd_ch.operand_value = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Empty table: every search and delete misses
		send_command(OP_LOOKUP, 32'd5);
		send_command(OP_DELETE, 32'd5);
		send_command(OP_FIRST_GT, 32'd0);
		// Extremes and duplicates land after equal entries
		send_command(OP_INSERT, 32'hFFFF_FFFF);
		send_command(OP_INSERT, 32'h0000_0000);
		send_command(OP_INSERT, 32'd100);
		send_command(OP_INSERT, 32'd100);
		send_command(OP_INSERT, 32'd100);
		send_command(OP_INSERT, 32'd50);
		send_command(OP_LOOKUP, 32'd100);
		send_command(OP_LOOKUP, 32'h0000_0000);
		send_command(OP_LOOKUP, 32'hFFFF_FFFF);
		send_command(OP_LOOKUP, 32'd77);
		send_command(OP_FIRST_GT, 32'd100);
		send_command(OP_FIRST_GT, 32'hFFFF_FFFF);
		send_command(OP_FIRST_GT, 32'h0000_0000);
		send_command(OP_FIRST_GT, 32'h8000_0000);
		send_command(OP_DELETE, 32'd100);
		send_command(OP_DELETE, 32'd77);
		send_command(OP_DELETE, 32'h0000_0000);
		send_command(OP_DELETE, 32'hFFFF_FFFF);
		send_command(OP_INSERT, 32'hAAAA_AAAA);
		send_command(OP_INSERT, 32'h5555_5555);
		drain_responses();

		// Random phases: fill to full, drain to empty, mixed traffic
		sent = 0;
		phase = 0;
		while (sent < RANDOM_BEATS) begin
			if (phase < 3)
				mix = (phase == 1) ? DRAIN_MIX : FILL_MIX;
			else
				mix = mix_kind_t'($urandom_range(0, 2));
			steady = (phase % 4 == 2);
			len = (phase == 0) ? 160 : $urandom_range(60, 160);
			if (len > RANDOM_BEATS - sent)
				len = RANDOM_BEATS - sent;
			repeat (len) begin
				send_random(mix);
				sent++;
			end
			drain_responses();
			phase++;
		end
		steady = 1'b0;

		// Let the last responses come back, then settle
		cmd_ch.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.errors == 0)
			$display("sorted_array_insert_delete_search regression: pass");
		else
			$display("sorted_array_insert_delete_search regression: fail");
		$finish;
	end

endmodule
